>>> hw/rtl/cctsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cctsd_pkg
// Shared types, constants and wheel tables for the crank/cam tooth decoder.
// ----------------------------------------------------------------------------
package cctsd_pkg;

    // widths fixed by the word formats
    localparam int TIME_BITS_DEF = 32;
    localparam int EVT_TIME_W    = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    // event kinds
    localparam logic CMD_CRANK = 1'b0;
    localparam logic CMD_CAM   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CRANK_FILTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET = 2'd1;

    // configuration reset values
    localparam logic [15:0]       CRANK_FILTER_RST = 16'd9;
    localparam logic signed [9:0] ANGLE_OFFSET_RST = 10'sd0;

    // tooth numbering over 720 degrees
    localparam logic [3:0] TOOTH_RST      = 4'd1;
    localparam logic [3:0] TOOTH_FIRST    = 4'd1;
    localparam logic [3:0] TOOTH_LAST     = 4'd12;
    localparam logic [3:0] TOOTH_MAX      = 4'd13;
    localparam logic [3:0] TOOTH_CAM1_A   = 4'd5;
    localparam logic [3:0] TOOTH_CAM1_B   = 4'd11;
    localparam logic [3:0] TOOTH_CAM2     = 4'd8;
    localparam logic [3:0] TOOTH_CAM3     = 4'd2;
    localparam logic [3:0] COUNT_SAT      = 4'd15;
    localparam logic [3:0] CAM_WINDOW     = 4'd3;
    localparam logic [6:0] GAP_ANGLE_RST  = 7'd2;

    typedef struct packed {
        logic                event_accepted;
        logic [3:0]          tooth_number;
        logic                in_sync;
        logic                gap_angle_valid;
        logic [6:0]          gap_angle;
        logic signed [11:0]  tooth_position;
        logic [7:0]          sync_losses;
        logic [31:0]         cycles_completed;
        logic                cycle_start;
        logic [31:0]         tooth_gap_us;
    } cctsd_res_t;

    // table angle of each tooth in degrees
    function automatic logic [9:0] tooth_angle(input logic [3:0] tooth);
        logic [9:0] a;
        case (tooth)
            4'd1:    a = 10'd710;
            4'd2:    a = 10'd83;
            4'd3:    a = 10'd115;
            4'd4:    a = 10'd170;
            4'd5:    a = 10'd263;
            4'd6:    a = 10'd295;
            4'd7:    a = 10'd350;
            4'd8:    a = 10'd443;
            4'd9:    a = 10'd475;
            4'd10:   a = 10'd530;
            4'd11:   a = 10'd623;
            4'd12:   a = 10'd655;
            default: a = 10'd0;
        endcase
        return a;
    endfunction

    // angle from the previous tooth to this one
    function automatic logic [6:0] gap_for_tooth(input logic [3:0] tooth,
                                                 input logic [6:0] last_gap);
        logic [6:0] g;
        case (tooth)
            4'd1, 4'd4, 4'd7, 4'd10:  g = 7'd55;
            4'd2, 4'd5, 4'd8, 4'd11:  g = 7'd93;
            4'd3, 4'd6, 4'd9, 4'd12:  g = 7'd32;
            default:                  g = last_gap;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cctsd_evt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cctsd_evt_if
// Tooth event channel: event kind and timestamp with valid/ready.
// ----------------------------------------------------------------------------
interface cctsd_evt_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] event_time;

    modport source (output valid, output command, output event_time, input ready);
    modport sink   (input valid, input command, input event_time, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cctsd_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cctsd_res_if
// Decoder result channel: tooth, sync and angle status with valid/ready.
// ----------------------------------------------------------------------------
interface cctsd_res_if;
    logic               valid;
    logic               ready;
    logic               event_accepted;
    logic [3:0]         tooth_number;
    logic               in_sync;
    logic               gap_angle_valid;
    logic [6:0]         gap_angle;
    logic signed [11:0] tooth_position;
    logic [7:0]         sync_losses;
    logic [31:0]        cycles_completed;
    logic               cycle_start;
    logic [31:0]        tooth_gap_us;

    modport source (
        output valid, output event_accepted, output tooth_number, output in_sync,
        output gap_angle_valid, output gap_angle, output tooth_position,
        output sync_losses, output cycles_completed, output cycle_start,
        output tooth_gap_us, input ready
    );
    modport sink (
        input valid, input event_accepted, input tooth_number, input in_sync,
        input gap_angle_valid, input gap_angle, input tooth_position,
        input sync_losses, input cycles_completed, input cycle_start,
        input tooth_gap_us, output ready
    );
endinterface
`default_nettype wire

>>> hw/rtl/cctsd_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cctsd_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface cctsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/crank_cam_tooth_sync_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crank_cam_tooth_sync_decoder_unit
// Decoder for a 6-tooth crank and 7-tooth cam wheel: filters tooth edges,
// counts crank teeth over 720 degrees and syncs on the cam pulse pattern.
// ----------------------------------------------------------------------------
// a word accepted into the input register has its result held in the result register
// throughput: one word per cycle while res.ready does not stall the result register, set by
//   the input register feeding the combinational decode into the result register
// config writes are always accepted (ready always high)
// reset: decoder state to tooth 1, out of sync, counters zero; filter 9 us,
//   offset 0; both channel valid registers cleared
module crank_cam_tooth_sync_decoder_unit
    import cctsd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire          clk,
    input  wire          rst_n,
    cctsd_evt_if.sink    evt,
    cctsd_res_if.source  res,
    cctsd_cfg_if.sink    cfg
);

    // input register
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_cmd_reg;
    logic [EVT_TIME_W-1:0]  s1_time_reg;

    // result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    cctsd_res_t             res_reg;
    cctsd_res_t             res_next;

    // configuration
    logic [15:0]            crank_filt_reg;
    logic signed [9:0]      offset_reg;

    // decoder state
    logic [3:0]             tooth_reg, tooth_next;
    logic [3:0]             cam_cnt_reg, cam_cnt_next;
    logic [3:0]             csc_reg, csc_next;
    logic [TIME_BITS-1:0]   last_tooth_reg, last_tooth_next;
    logic [TIME_BITS-1:0]   last_cam_reg, last_cam_next;
    logic [TIME_BITS-3:0]   cam_filt_reg, cam_filt_next;
    logic                   sync_reg, sync_next;
    logic                   angle_known_reg, angle_known_next;
    logic [6:0]             gap_angle_reg, gap_angle_next;
    logic [7:0]             loss_reg, loss_next;
    logic [31:0]            cycle_reg, cycle_next;

    logic                   fire;
    logic                   accepted;
    logic                   new_cycle;
    logic [1:0]             loss_inc;
    logic [TIME_BITS-1:0]   now;
    logic [TIME_BITS-1:0]   gap;
    logic [63:0]            gap_wide;
    logic signed [11:0]     pos;

    assign fire      = s1_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready = !s1_valid_reg || fire;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (evt.valid && evt.ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // decode of the word in the input register
    always_comb
    begin
        now              = TIME_BITS'(s1_time_reg);
        tooth_next       = tooth_reg;
        cam_cnt_next     = cam_cnt_reg;
        csc_next         = csc_reg;
        last_tooth_next  = last_tooth_reg;
        last_cam_next    = last_cam_reg;
        cam_filt_next    = cam_filt_reg;
        sync_next        = sync_reg;
        angle_known_next = angle_known_reg;
        gap_angle_next   = gap_angle_reg;
        cycle_next       = cycle_reg;
        accepted         = 1'b0;
        new_cycle        = 1'b0;
        loss_inc         = 2'd0;

        if (s1_cmd_reg == CMD_CRANK)
        begin
            gap = now - last_tooth_reg;
            if (gap >= TIME_BITS'(crank_filt_reg))
            begin
                accepted        = 1'b1;
                last_tooth_next = now;
                if (csc_reg != COUNT_SAT)
                begin
                    csc_next = csc_reg + 4'd1;
                end
                // count runs past the last slot: lost
                if (tooth_reg >= TOOTH_MAX)
                begin
                    tooth_next = 4'd0;
                    sync_next  = 1'b0;
                    loss_inc   = 2'd1;
                end
                else
                begin
                    tooth_next = tooth_reg + 4'd1;
                end

                case (cam_cnt_reg)
                    4'd0:
                    begin
                        cam_cnt_next = cam_cnt_reg;
                    end
                    4'd1:
                    begin
                        if (tooth_next == TOOTH_CAM1_A || tooth_next == TOOTH_CAM1_B)
                        begin
                            sync_next = 1'b1;
                        end
                        else
                        begin
                            sync_next  = 1'b0;
                            loss_inc   = loss_inc + 2'd1;
                            tooth_next = TOOTH_CAM1_A;
                        end
                        cam_cnt_next = 4'd0;
                    end
                    4'd2:
                    begin
                        if (tooth_next == TOOTH_CAM2)
                        begin
                            sync_next = 1'b1;
                        end
                        else
                        begin
                            sync_next  = 1'b0;
                            loss_inc   = loss_inc + 2'd1;
                            tooth_next = TOOTH_CAM2;
                        end
                        cam_cnt_next = 4'd0;
                    end
                    4'd3:
                    begin
                        if (tooth_next == TOOTH_CAM3)
                        begin
                            sync_next = 1'b1;
                        end
                        else
                        begin
                            sync_next  = 1'b0;
                            loss_inc   = loss_inc + 2'd1;
                            tooth_next = TOOTH_CAM3;
                        end
                        cam_cnt_next = 4'd0;
                    end
                    default:
                    begin
                        // too many cam pulses
                        sync_next        = 1'b0;
                        loss_inc         = loss_inc + 2'd1;
                        angle_known_next = 1'b0;
                        cam_cnt_next     = 4'd0;
                    end
                endcase

                if (sync_next)
                begin
                    if (tooth_next > TOOTH_LAST)
                    begin
                        tooth_next = TOOTH_FIRST;
                        cycle_next = cycle_reg + 32'd1;
                        new_cycle  = 1'b1;
                    end
                    gap_angle_next   = gap_for_tooth(tooth_next, gap_angle_reg);
                    angle_known_next = 1'b1;
                end
            end
        end
        else
        begin
            gap = now - last_cam_reg;
            if (csc_reg == 4'd0 || csc_reg == CAM_WINDOW)
            begin
                if (gap > {2'b00, cam_filt_reg})
                begin
                    accepted      = 1'b1;
                    last_cam_next = now;
                    if (cam_cnt_reg != COUNT_SAT)
                    begin
                        cam_cnt_next = cam_cnt_reg + 4'd1;
                    end
                    csc_next = 4'd0;
                    // quarter of the last cam gap once a pulse train is running
                    cam_filt_next = (cam_cnt_next > 4'd1) ? gap[TIME_BITS-1:2] : '0;
                end
            end
            else
            begin
                if (csc_reg > CAM_WINDOW)
                begin
                    csc_next  = 4'd0;
                    sync_next = 1'b0;
                    loss_inc  = 2'd1;
                end
                cam_cnt_next = 4'd0;
            end
        end

        loss_next = loss_reg + 8'(loss_inc);

        if (tooth_next == 4'd0 || tooth_next > TOOTH_LAST)
        begin
            pos = '0;
        end
        else
        begin
            pos = $signed({2'b00, tooth_angle(tooth_next)}) + 12'(offset_reg);
        end

        gap_wide = 64'(gap);

        res_next.event_accepted   = accepted;
        res_next.tooth_number     = tooth_next;
        res_next.in_sync          = sync_next;
        res_next.gap_angle_valid  = angle_known_next;
        res_next.gap_angle        = gap_angle_next;
        res_next.tooth_position   = pos;
        res_next.sync_losses      = loss_next;
        res_next.cycles_completed = cycle_next;
        res_next.cycle_start      = new_cycle;
        res_next.tooth_gap_us     = gap_wide[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            crank_filt_reg  <= CRANK_FILTER_RST;
            offset_reg      <= ANGLE_OFFSET_RST;
            tooth_reg       <= TOOTH_RST;
            cam_cnt_reg     <= 4'd0;
            csc_reg         <= 4'd0;
            last_tooth_reg  <= '0;
            last_cam_reg    <= '0;
            cam_filt_reg    <= '0;
            sync_reg        <= 1'b0;
            angle_known_reg <= 1'b0;
            gap_angle_reg   <= GAP_ANGLE_RST;
            loss_reg        <= 8'd0;
            cycle_reg       <= 32'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_CRANK_FILTER: crank_filt_reg <= cfg.data;
                    REG_ANGLE_OFFSET: offset_reg     <= $signed(cfg.data[9:0]);
                    default:          crank_filt_reg <= crank_filt_reg;
                endcase
            end
            if (fire)
            begin
                tooth_reg       <= tooth_next;
                cam_cnt_reg     <= cam_cnt_next;
                csc_reg         <= csc_next;
                last_tooth_reg  <= last_tooth_next;
                last_cam_reg    <= last_cam_next;
                cam_filt_reg    <= cam_filt_next;
                sync_reg        <= sync_next;
                angle_known_reg <= angle_known_next;
                gap_angle_reg   <= gap_angle_next;
                loss_reg        <= loss_next;
                cycle_reg       <= cycle_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            s1_cmd_reg  <= evt.command;
            s1_time_reg <= evt.event_time;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.event_accepted   = res_reg.event_accepted;
    assign res.tooth_number     = res_reg.tooth_number;
    assign res.in_sync          = res_reg.in_sync;
    assign res.gap_angle_valid  = res_reg.gap_angle_valid;
    assign res.gap_angle        = res_reg.gap_angle;
    assign res.tooth_position   = res_reg.tooth_position;
    assign res.sync_losses      = res_reg.sync_losses;
    assign res.cycles_completed = res_reg.cycles_completed;
    assign res.cycle_start      = res_reg.cycle_start;
    assign res.tooth_gap_us     = res_reg.tooth_gap_us;

`ifndef NO_ASSERTIONS
    a_tooth_range: assert property (@(posedge clk) disable iff (!rst_n)
        tooth_reg <= TOOTH_MAX)
        else $error("tooth count out of range");

    a_cycle_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && new_cycle |=> cycle_reg == $past(cycle_reg) + 32'd1)
        else $error("cycle count did not step on a cycle start");

    a_cycle_start_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.cycle_start |->
            res_reg.in_sync && res_reg.tooth_number == TOOTH_FIRST)
        else $error("cycle start without sync at the first tooth");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(loss_reg) && $stable(tooth_reg) && $stable(cycle_reg))
        else $error("decoder state moved without a word");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !res.ready |-> !evt.ready)
        else $error("input taken while both stages are full");
`endif

endmodule
`default_nettype wire
